// ===== sv/tacl_pkg.sv =====
// Shared types and constants for the tiled array chunk locator.
`default_nettype none
package tacl_pkg;

    localparam int RankDef  = 3;
    localparam int BeginW   = 32;
    localparam int LenW     = 31;
    localparam int SizeW    = 31;
    localparam int QuoW     = 31;
    localparam int CountW   = 32;
    localparam int IndexW   = 64;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 32;
    localparam int StatusW  = 2;

    typedef enum logic [StatusW-1:0] {
        ST_OK   = 2'd0,
        ST_OOB  = 2'd1,
        ST_SPAN = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_IDLE,
        CFG_LOAD,
        CFG_DIV
    } t_cfg_state;

    // per-dimension result handed from the check stage to the index chain
    typedef struct packed {
        t_status            code;
        logic [QuoW-1:0]    k;
        logic [SizeW-1:0]   off;
        logic [SizeW-1:0]   ext;
    } t_dim_res;

endpackage
`default_nettype wire

// ===== sv/tacl_cfg.sv =====
// Configuration registers and the iterative chunks-per-dimension divider.
`default_nettype none
module tacl_cfg #(
    parameter int RANK = tacl_pkg::RankDef
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [tacl_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire  [tacl_pkg::CfgDataW-1:0]  i_cfg_data,
    output logic [tacl_pkg::SizeW-1:0]     o_csz [RANK],
    output logic [tacl_pkg::SizeW-1:0]     o_gsz [RANK],
    output logic [tacl_pkg::CountW-1:0]    o_nch [RANK],
    output logic                           o_busy
);
    localparam int DimW = (RANK > 1) ? $clog2(RANK) : 1;
    localparam int CntW = $clog2(tacl_pkg::CountW);
    localparam int SW   = tacl_pkg::SizeW;
    localparam int NW   = tacl_pkg::CountW;

    tacl_pkg::t_cfg_state r_state, n_state;
    logic [DimW-1:0] r_dim;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [SW-1:0]   r_rem, n_rem;
    logic [NW-1:0]   r_dq, n_dq;
    logic            n_wr;
    logic [NW-1:0]   n_wr_val;
    logic [SW-1:0]   r_csz [RANK];
    logic [SW-1:0]   r_gsz [RANK];
    logic [NW-1:0]   r_nch [RANK];
    logic            wr_fire;
    logic            wr_csz, wr_gsz;
    logic [tacl_pkg::CfgIdxW-1:0] gidx;
    logic [SW-1:0]   cur_c;
    logic [NW-1:0]   t_sh;
    logic            ge;

    assign wr_fire = i_cfg_valid && o_cfg_ready;
    assign wr_csz  = wr_fire && (i_cfg_index < tacl_pkg::CfgIdxW'(RANK));
    assign wr_gsz  = wr_fire && !wr_csz && (i_cfg_index < tacl_pkg::CfgIdxW'(2 * RANK));
    assign gidx    = i_cfg_index - tacl_pkg::CfgIdxW'(RANK);
    assign cur_c   = r_csz[r_dim];
    assign t_sh    = {r_rem, r_dq[NW-1]};
    assign ge      = t_sh >= {1'b0, cur_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < RANK; d++) begin
                r_csz[d] <= SW'(1);
                r_gsz[d] <= '0;
            end
            r_dim <= '0;
        end else if (wr_csz) begin
            r_csz[i_cfg_index[DimW-1:0]] <= i_cfg_data[SW-1:0];
            r_dim <= i_cfg_index[DimW-1:0];
        end else if (wr_gsz) begin
            r_gsz[gidx[DimW-1:0]] <= i_cfg_data[SW-1:0];
            r_dim <= gidx[DimW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tacl_pkg::CFG_IDLE;
            r_cnt   <= '0;
            for (int d = 0; d < RANK; d++) r_nch[d] <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (n_wr) r_nch[r_dim] <= n_wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dq  <= n_dq;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_dq     = r_dq;
        n_wr     = 1'b0;
        n_wr_val = '0;
        case (r_state)
            tacl_pkg::CFG_IDLE: begin
                if (wr_csz || wr_gsz) n_state = tacl_pkg::CFG_LOAD;
            end
            tacl_pkg::CFG_LOAD: begin
                // ceil(g / c) as floor((g + c - 1) / c)
                n_rem = '0;
                n_dq  = {1'b0, r_gsz[r_dim]} + {1'b0, cur_c} - NW'(1);
                n_cnt = '0;
                if (cur_c == '0) begin
                    n_wr    = 1'b1;
                    n_state = tacl_pkg::CFG_IDLE;
                end else begin
                    n_state = tacl_pkg::CFG_DIV;
                end
            end
            tacl_pkg::CFG_DIV: begin
                n_rem = ge ? SW'(t_sh - {1'b0, cur_c}) : SW'(t_sh);
                n_dq  = {r_dq[NW-2:0], ge};
                n_cnt = r_cnt + CntW'(1);
                if (r_cnt == CntW'(NW - 1)) begin
                    n_wr     = 1'b1;
                    n_wr_val = n_dq;
                    n_state  = tacl_pkg::CFG_IDLE;
                end
            end
            default: n_state = tacl_pkg::CFG_IDLE;
        endcase
    end

    assign o_busy      = r_state != tacl_pkg::CFG_IDLE;
    assign o_cfg_ready = !o_busy;
    assign o_csz       = r_csz;
    assign o_gsz       = r_gsz;
    assign o_nch       = r_nch;

endmodule
`default_nettype wire

// ===== sv/tacl_div.sv =====
// Pipelined restoring divider lane, one quotient bit per stage.
`default_nettype none
module tacl_div #(
    parameter int SideW = 1
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_en,
    input  wire                         i_vld,
    input  wire  [tacl_pkg::QuoW-1:0]   i_dvd,
    input  wire  [tacl_pkg::SizeW-1:0]  i_dvs,
    input  wire  [SideW-1:0]            i_side,
    output logic                        o_vld,
    output logic [tacl_pkg::QuoW-1:0]   o_quo,
    output logic [tacl_pkg::SizeW-1:0]  o_rem,
    output logic [SideW-1:0]            o_side
);
    localparam int QW = tacl_pkg::QuoW;
    localparam int RW = tacl_pkg::SizeW;

    logic [QW-1:0]    r_vld;
    logic [RW-1:0]    r_rem  [QW];
    logic [QW-1:0]    r_dq   [QW];
    logic [SideW-1:0] r_side [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [RW-1:0]    rem_in;
        logic [QW-1:0]    dq_in;
        logic             v_in;
        logic [SideW-1:0] s_in;
        logic [RW:0]      t_sh;
        logic [RW:0]      diff;
        logic             ge;

        if (j == 0) begin : g_first
            assign rem_in = '0;
            assign dq_in  = i_dvd;
            assign v_in   = i_vld;
            assign s_in   = i_side;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign dq_in  = r_dq[j-1];
            assign v_in   = r_vld[j-1];
            assign s_in   = r_side[j-1];
        end

        assign t_sh = {rem_in, dq_in[QW-1]};
        assign diff = t_sh - {1'b0, i_dvs};
        assign ge   = t_sh >= {1'b0, i_dvs};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= ge ? diff[RW-1:0] : t_sh[RW-1:0];
                r_dq[j]   <= {dq_in[QW-2:0], ge};
                r_side[j] <= s_in;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_dq[QW-1];
    assign o_rem  = r_rem[QW-1];
    assign o_side = r_side[QW-1];

endmodule
`default_nettype wire

// ===== sv/tacl_idx.sv =====
// Row-major index accumulation and status priority, two stages per dimension.
`default_nettype none
module tacl_idx #(
    parameter int RANK = tacl_pkg::RankDef
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_en,
    input  wire                                i_vld,
    input  wire tacl_pkg::t_dim_res [RANK-1:0] i_dim,
    input  wire  [tacl_pkg::CountW-1:0]        i_nch [RANK],
    output logic                               o_vld,
    output tacl_pkg::t_status                  o_status,
    output logic [tacl_pkg::IndexW-1:0]        o_index,
    output tacl_pkg::t_dim_res [RANK-1:0]      o_dim
);
    localparam int IW = tacl_pkg::IndexW;
    localparam int HW = IW / 2;

    // multiply stage
    logic [RANK-1:0]               r_vm;
    logic [IW-1:0]                 r_plo [RANK];
    logic [HW-1:0]                 r_phi [RANK];
    tacl_pkg::t_dim_res [RANK-1:0] r_dm  [RANK];
    tacl_pkg::t_status             r_stm [RANK];
    // accumulate stage
    logic [RANK-1:0]               r_va;
    logic [IW-1:0]                 r_acc [RANK];
    tacl_pkg::t_dim_res [RANK-1:0] r_da  [RANK];
    tacl_pkg::t_status             r_sta [RANK];

    for (genvar d = 0; d < RANK; d++) begin : g_dim
        logic                          v_in;
        logic [IW-1:0]                 acc_in;
        tacl_pkg::t_dim_res [RANK-1:0] dim_in;
        tacl_pkg::t_status             st_in;
        logic [IW-1:0]                 sum;

        if (d == 0) begin : g_first
            assign v_in   = i_vld;
            assign acc_in = '0;
            assign dim_in = i_dim;
            assign st_in  = tacl_pkg::ST_OK;
        end else begin : g_next
            assign v_in   = r_va[d-1];
            assign acc_in = r_acc[d-1];
            assign dim_in = r_da[d-1];
            assign st_in  = r_sta[d-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vm[d] <= 1'b0;
                r_va[d] <= 1'b0;
            end else if (i_en) begin
                r_vm[d] <= v_in;
                r_va[d] <= r_vm[d];
            end
        end

        // acc * n mod 2^64 split into two 32x32 products
        assign sum = r_plo[d] + {r_phi[d], {HW{1'b0}}} + IW'(r_dm[d][d].k);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_plo[d] <= acc_in[HW-1:0] * i_nch[d];
                r_phi[d] <= HW'(acc_in[IW-1:HW] * i_nch[d]);
                r_dm[d]  <= dim_in;
                r_stm[d] <= st_in;
                r_acc[d] <= sum;
                r_da[d]  <= r_dm[d];
                r_sta[d] <= (r_stm[d] == tacl_pkg::ST_OK) ? r_dm[d][d].code : r_stm[d];
            end
        end
    end

    assign o_vld    = r_va[RANK-1];
    assign o_status = r_sta[RANK-1];
    assign o_index  = r_acc[RANK-1];
    assign o_dim    = r_da[RANK-1];

endmodule
`default_nettype wire

// ===== sv/tiled_array_chunk_locator.sv =====
// Top level of the tiled array chunk locator.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  region: begin_d, length_d
//  m_axis    out  m_axis_tvalid / m_axis_tready  status, chunk_index, offset_d, extent_d
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One region per cycle while no config write is busy and the skid is empty;
// regions pass the one-bit-per-stage divider lanes and the index multiply chain.
// A config write holds both ready lines low while the chunk count of that
// dimension is divided out. Reset is synchronous.
// A skid register at the output absorbs one result; the pipe then freezes.
`default_nettype none
module tiled_array_chunk_locator #(
    parameter int RANK = tacl_pkg::RankDef
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // begin_0..begin_{RANK-1} (32b each), length_0..length_{RANK-1} (31b each), zero pad
    input  wire  [((RANK*63+7)/8)*8-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // status (2b), chunk_index (64b), offset_0.. (31b each), extent_0.. (31b each), zero pad
    output logic [((RANK*62+66+7)/8)*8-1:0] m_axis_tdata,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [tacl_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire  [tacl_pkg::CfgDataW-1:0] i_cfg_data
);
    localparam int OutW  = ((RANK * 62 + 66 + 7) / 8) * 8;
    localparam int BW    = tacl_pkg::BeginW;
    localparam int LW    = tacl_pkg::LenW;
    localparam int SW    = tacl_pkg::SizeW;
    localparam int QW    = tacl_pkg::QuoW;
    localparam int NW    = tacl_pkg::CountW;
    localparam int SideW = 1 + SW + LW;
    localparam int OffB  = tacl_pkg::StatusW + tacl_pkg::IndexW;
    localparam int ExtB  = OffB + RANK * SW;

    logic            cfg_busy;
    logic [SW-1:0]   csz [RANK];
    logic [SW-1:0]   gsz [RANK];
    logic [NW-1:0]   nch [RANK];
    logic            en;
    logic            in_fire;

    logic [RANK-1:0]    dv_vld;
    logic [QW-1:0]      dv_quo  [RANK];
    logic [SW-1:0]      dv_rem  [RANK];
    logic [SideW-1:0]   dv_side [RANK];

    logic                          r_vc;
    tacl_pkg::t_dim_res [RANK-1:0] r_dc;

    logic                          ix_vld;
    tacl_pkg::t_status             ix_status;
    logic [tacl_pkg::IndexW-1:0]   ix_index;
    tacl_pkg::t_dim_res [RANK-1:0] ix_dim;
    logic [OutW-1:0]               push_data;
    logic                          push;

    logic            r_out_vld, r_skid_vld;
    logic [OutW-1:0] r_out, r_skid;

    tacl_cfg #(.RANK(RANK)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_csz       (csz),
        .o_gsz       (gsz),
        .o_nch       (nch),
        .o_busy      (cfg_busy)
    );

    assign en            = !r_skid_vld;
    assign s_axis_tready = en && !cfg_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    for (genvar d = 0; d < RANK; d++) begin : g_lane
        logic [BW-1:0] bgn;
        logic [LW-1:0] len;
        logic          neg;
        logic [SW-1:0] b_c, r_c, lo, glo, ext;
        logic [LW-1:0] len_c;
        logic          oob, span;

        assign bgn = s_axis_tdata[d*BW +: BW];
        assign len = s_axis_tdata[RANK*BW + d*LW +: LW];

        tacl_div #(.SideW(SideW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (in_fire),
            .i_dvd   (bgn[QW-1:0]),
            .i_dvs   (csz[d]),
            .i_side  ({len, bgn[SW-1:0], bgn[BW-1]}),
            .o_vld   (dv_vld[d]),
            .o_quo   (dv_quo[d]),
            .o_rem   (dv_rem[d]),
            .o_side  (dv_side[d])
        );

        assign neg   = dv_side[d][0];
        assign b_c   = dv_side[d][SW:1];
        assign len_c = dv_side[d][SideW-1:SW+1];
        assign r_c   = dv_rem[d];
        // negative begin always floors to a negative chunk number
        assign oob   = neg || ({1'b0, dv_quo[d]} >= nch[d]);
        // len > chunk end - begin, or len > array end - begin
        assign span  = (({1'b0, len_c} + {1'b0, r_c}) > {1'b0, csz[d]})
                    || (({1'b0, len_c} + {1'b0, b_c}) > {1'b0, gsz[d]});
        assign lo    = b_c - r_c;
        assign glo   = gsz[d] - lo;
        assign ext   = (csz[d] < glo) ? csz[d] : glo;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dc[d].code <= oob ? tacl_pkg::ST_OOB
                              : (span ? tacl_pkg::ST_SPAN : tacl_pkg::ST_OK);
                r_dc[d].k    <= dv_quo[d];
                r_dc[d].off  <= lo;
                r_dc[d].ext  <= ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (en) begin
            r_vc <= dv_vld[0];
        end
    end

    tacl_idx #(.RANK(RANK)) u_idx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (r_vc),
        .i_dim    (r_dc),
        .i_nch    (nch),
        .o_vld    (ix_vld),
        .o_status (ix_status),
        .o_index  (ix_index),
        .o_dim    (ix_dim)
    );

    always_comb begin
        push_data = '0;
        push_data[tacl_pkg::StatusW-1:0] = ix_status;
        if (ix_status == tacl_pkg::ST_OK) begin
            push_data[tacl_pkg::StatusW +: tacl_pkg::IndexW] = ix_index;
            for (int d = 0; d < RANK; d++) begin
                push_data[OffB + d*SW +: SW] = ix_dim[d].off;
                push_data[ExtB + d*SW +: SW] = ix_dim[d].ext;
            end
        end
    end

    assign push = en && ix_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || m_axis_tready) begin
            r_out_vld  <= r_skid_vld || push;
            r_skid_vld <= 1'b0;
        end else if (push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || m_axis_tready) begin
            r_out <= r_skid_vld ? r_skid : push_data;
        end else if (push) begin
            r_skid <= push_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a result while output is empty");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_busy |-> !s_axis_tready)
        else $error("region accepted during chunk count update");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out[tacl_pkg::StatusW-1:0] == tacl_pkg::ST_OK
                    || r_out[tacl_pkg::StatusW-1:0] == tacl_pkg::ST_OOB
                    || r_out[tacl_pkg::StatusW-1:0] == tacl_pkg::ST_SPAN))
        else $error("illegal status code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out[tacl_pkg::StatusW-1:0] != tacl_pkg::ST_OK)
            |-> (r_out[OutW-1:tacl_pkg::StatusW] == '0))
        else $error("error result carries nonzero fields");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !m_axis_tready) |=> (r_skid_vld && $stable(r_skid)))
        else $error("skid lost a result under stall");

endmodule
`default_nettype wire

// ===== sim/tacl_checker.sv =====
// Watches the locator channels, predicts each chunk lookup and compares results.
`timescale 1ns / 1ps
module tacl_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_valid,
    input  wire          i_s_ready,
    input  wire  [191:0] i_s_data,
    input  wire          i_m_valid,
    input  wire          i_m_ready,
    input  wire  [255:0] i_m_data,
    input  wire          i_cfg_valid,
    input  wire          i_cfg_ready,
    input  wire  [7:0]   i_cfg_index,
    input  wire  [31:0]  i_cfg_data,
    output int           o_errors,
    output int           o_pending,
    output int           o_results
);
    typedef struct packed {
        tacl_pkg::t_status st;
        logic [63:0]       idx;
        logic [2:0][30:0]  off;
        logic [2:0][30:0]  ext;
    } t_lookup;

    longint  chunk_len [3];
    longint  array_len [3];
    longint  chunk_cnt [3];
    t_lookup expected_lookups[$];

    function automatic t_lookup locate(logic [191:0] d);
        t_lookup r;
        longint  b, len, c, n, k, g, lo, hi;
        logic [63:0] idx;
        r   = '0;
        idx = '0;
        r.st = tacl_pkg::ST_OK;
        for (int i = 0; i < 3; i++) begin
            b   = longint'($signed(d[i*32 +: 32]));
            len = longint'(d[96 + i*31 +: 31]);
            c   = chunk_len[i];
            n   = chunk_cnt[i];
            if (c == 0) begin
                r.st = tacl_pkg::ST_OOB;
                break;
            end
            k = b / c;
            if ((b % c) != 0 && b < 0) k--;   // floor toward minus infinity
            if (k < 0 || k >= n) begin
                r.st = tacl_pkg::ST_OOB;
                break;
            end
            g  = array_len[i];
            lo = k * c;
            hi = (k + 1) * c;
            if (hi > g) hi = g;
            if (len > hi - b) begin
                r.st = tacl_pkg::ST_SPAN;
                break;
            end
            r.off[i] = lo[30:0];
            r.ext[i] = 31'(hi - lo);
            idx = idx * 64'(n) + 64'(k);
        end
        if (r.st != tacl_pkg::ST_OK) begin
            r     = '0;
            r.st  = (c == 0 || k < 0 || k >= n) ? tacl_pkg::ST_OOB : tacl_pkg::ST_SPAN;
        end else begin
            r.idx = idx;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lookup got, exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                chunk_len[i] = 1;
                array_len[i] = 0;
                chunk_cnt[i] = 0;
            end
            expected_lookups.delete();
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index < 3) chunk_len[i_cfg_index] = i_cfg_data[30:0];
                else if (i_cfg_index < 6) array_len[i_cfg_index-3] = i_cfg_data[30:0];
                for (int i = 0; i < 3; i++)
                    chunk_cnt[i] = (chunk_len[i] == 0) ? 0 :
                        ((array_len[i] + chunk_len[i] - 1) / chunk_len[i]) & 64'hFFFF_FFFF;
            end
            if (i_m_valid && i_m_ready) begin
                o_results <= o_results + 1;
                got.st  = tacl_pkg::t_status'(i_m_data[1:0]);
                got.idx = i_m_data[65:2];
                for (int i = 0; i < 3; i++) begin
                    got.off[i] = i_m_data[66 + i*31 +: 31];
                    got.ext[i] = i_m_data[159 + i*31 +: 31];
                end
                if (expected_lookups.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_lookups.pop_front();
                    if (got.st !== exp_r.st || got.idx !== exp_r.idx ||
                        got.off !== exp_r.off || got.ext !== exp_r.ext) begin
                        $display("%0t: mismatch status exp %0d act %0d", $time,
                                 exp_r.st, got.st);
                        $display("    index exp %h act %h", exp_r.idx, got.idx);
                        $display("    offset exp %h act %h", exp_r.off, got.off);
                        $display("    extent exp %h act %h", exp_r.ext, got.ext);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_s_valid && i_s_ready)
                expected_lookups.push_back(locate(i_s_data));
        end
        o_pending <= expected_lookups.size();
    end
endmodule

// ===== sim/testbench.sv =====
// Stimulus and verdict for the tiled array chunk locator.
`timescale 1ns / 1ps
module testbench;
    localparam int CfgSettle = 60;
    localparam int IdleLimit = 5000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [255:0] m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    int  errors, pending, results;
    bit  s_fire, cfg_fire;
    bit  no_stall;
    int  idle_cycles;
    int  sent;
    longint cs [3];
    longint gs [3];

    always #10 i_clk = ~i_clk;

    tiled_array_chunk_locator u_top (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    tacl_checker u_chk (
        .i_clk, .i_rst_n,
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready), .i_s_data(s_axis_tdata),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready), .i_m_data(m_axis_tdata),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always @(posedge i_clk) begin
        s_fire   <= s_axis_tvalid && s_axis_tready;
        cfg_fire <= i_cfg_valid && o_cfg_ready;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("%0t: watchdog expired", $time);
            $display("[tiled_array_chunk_locator] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        if (no_stall || $urandom_range(3) != 0) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    // result side back-pressure
    int ready_gap = 0;
    always @(negedge i_clk) begin
        if (ready_gap > 0) begin
            m_axis_tready = 1'b0;
            ready_gap--;
        end else begin
            m_axis_tready = 1'b1;
            ready_gap = pick_gap();
        end
    end

    task automatic send_region(logic [2:0][31:0] b, logic [2:0][30:0] l);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {3'b0, l, b};
        s_axis_tvalid = 1'b1;
        do @(negedge i_clk); while (!s_fire);
        sent++;
    endtask

    task automatic write_reg(int idx, logic [31:0] val);
        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (CfgSettle) @(negedge i_clk);
        i_cfg_index = 8'(idx);
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid = 1'b0;
        if (idx < 3) cs[idx] = val[30:0];
        else if (idx < 6) gs[idx-3] = val[30:0];
    endtask

    task automatic set_dims(longint c0, c1, c2, g0, g1, g2);
        write_reg(0, 32'(c0)); write_reg(1, 32'(c1)); write_reg(2, 32'(c2));
        write_reg(3, 32'(g0)); write_reg(4, 32'(g1)); write_reg(5, 32'(g2));
    endtask

    task automatic region3(longint b0, b1, b2, l0, l1, l2);
        send_region({32'(b2), 32'(b1), 32'(b0)}, {31'(l2), 31'(l1), 31'(l0)});
    endtask

    // mostly aimed at real chunks, sometimes raw noise
    task automatic random_regions(int count);
        logic [2:0][31:0] b;
        logic [2:0][30:0] l;
        longint n, k, ofs;
        for (int j = 0; j < count; j++) begin
            for (int d = 0; d < 3; d++) begin
                if ($urandom_range(9) < 7 && cs[d] != 0) begin
                    n   = (gs[d] + cs[d] - 1) / cs[d];
                    k   = (n == 0) ? 0 : longint'($urandom_range(32'(n > 2 ? 2 : n)))
                          + (n > 3 ? longint'($urandom) % (n - 2) : 0);
                    if ($urandom_range(15) == 0) k = n - 1 + $urandom_range(1);
                    if ($urandom_range(15) == 0) k = -1;
                    ofs = longint'({$urandom, $urandom}) & 64'h7FFF_FFFF;
                    ofs = ofs % (cs[d] + 1);
                    b[d] = 32'(k * cs[d] + ofs);
                    l[d] = ($urandom_range(3) == 0) ? 31'($urandom)
                         : 31'(($urandom % 32'(cs[d] + 2)));
                    if ($urandom_range(3) == 0) l[d] = 31'(cs[d] - ofs);
                end else begin
                    b[d] = $urandom;
                    l[d] = 31'($urandom);
                end
            end
            send_region(b, l);
        end
    endtask

    initial begin
        for (int i = 0; i < 3; i++) begin
            cs[i] = 1;
            gs[i] = 0;
        end
        sent = 0;
        no_stall = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset state: no chunks anywhere
        region3(0, 0, 0, 0, 0, 0);
        region3(-1, 5, 7, 1, 2, 3);

        set_dims(4, 5, 6, 10, 11, 12);
        region3(0, 0, 0, 4, 5, 6);
        region3(9, 10, 11, 1, 1, 1);
        region3(4, 5, 6, 0, 0, 0);
        region3(10, 0, 0, 1, 0, 0);                       // past array end, last chunk
        region3(11, 0, 0, 0, 0, 0);
        region3(-1, 0, 0, 0, 0, 0);
        region3(-32'sh8000_0000, 0, 0, 0, 0, 0);
        region3(32'sh7FFF_FFFF, 0, 0, 0, 0, 0);
        region3(0, 0, 0, 31'h7FFF_FFFF, 0, 0);
        region3(0, 100, 0, 5, 0, 0);                      // dim 0 spans before dim 1 oob
        region3(0, 3, 100, 0, 3, 0);                      // dim 1 spans, dim 2 oob
        region3(0, 0, 12, 0, 0, 0);
        region3(3, 4, 5, 1, 1, 1);

        write_reg(6, 32'd0);                              // ignored indexes
        write_reg(255, 32'hFFFF_FFFF);
        write_reg(1, 32'h8000_0000);                      // chunk size 0 after masking
        region3(0, 0, 0, 0, 0, 0);
        region3(5, 5, 5, 1, 1, 1);

        set_dims(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        region3(0, 0, 0, 31'h7FFF_FFFF, 0, 1);
        region3(32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 1, 1, 0, 31'h7FFF_FFFE);
        random_regions(150);

        set_dims(1, 1, 1, 1, 1, 1);
        random_regions(150);
        set_dims(3, 7, 2, 40, 50, 9);
        random_regions(300);
        set_dims(1, 1, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        random_regions(250);                              // index wraps past 64 bits
        set_dims(16, 0, 5, 100, 100, 0);
        random_regions(100);
        no_stall = 1'b1;
        set_dims(1000, 31'h4000_0000, 13, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1000);
        random_regions(300);
        no_stall = 1'b0;
        for (int r = 0; r < 4; r++) begin
            set_dims($urandom_range(64, 1), $urandom_range(64, 1), $urandom_range(64, 1),
                     $urandom_range(500), $urandom_range(500), $urandom_range(500));
            random_regions(140);
        end

        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (CfgSettle) @(negedge i_clk);
        $display("Sent %0d regions across 11 chunk layouts, checked %0d results,", sent, results);
        $display("with reset, extreme, zero-size and ignored register settings.");
        if (errors == 0 && pending == 0)
            $display("[tiled_array_chunk_locator] OK");
        else
            $display("[tiled_array_chunk_locator] ERROR");
        $finish;
    end
endmodule
